/* hdl/hbbc_pkg.sv */
`timescale 1ns / 1ps
package hbbc_pkg;
  localparam int BufferCount = 32;
  localparam int BucketCount = 13;
  localparam int IdxW = 5;
  localparam int BktW = 4;

  localparam logic [1:0] OP_GET     = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_PIN     = 2'd2;
  localparam logic [1:0] OP_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_UNDER  = 2'd2;
  localparam logic [1:0] ST_OVER   = 2'd3;

  typedef struct packed {
    logic            load;
    logic            clr_scan;
    logic            step_hit;
    logic            step_vic;
    logic            next_bucket;
    logic            commit;
    logic [1:0]      kind;
  } hbbc_cmd_t;

  localparam logic [1:0] K_HIT  = 2'd0;
  localparam logic [1:0] K_VIC  = 2'd1;
  localparam logic [1:0] K_IDX  = 2'd2;
  localparam logic [1:0] K_FAIL = 2'd3;

  typedef struct packed {
    logic is_get;
    logic scan_last;
    logic hit_found;
    logic vic_found;
    logic bucket_last;
  } hbbc_sts_t;
endpackage

/* hdl/hbbc_ctrl.sv */
`timescale 1ns / 1ps
module hbbc_ctrl import hbbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_busy,
  input  hbbc_sts_t sts,
  output logic      in_ready,
  output hbbc_cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_MOD, S_HIT, S_VIC, S_DONE} state_t;
  state_t state_r, state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    in_ready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        // bucket computed in datapath over this cycle
        cmd.clr_scan = 1'b1;
        state_nxt = sts.is_get ? S_HIT : S_DONE;
      end
      S_HIT: begin
        cmd.step_hit = 1'b1;
        if (sts.scan_last) begin
          cmd.clr_scan = 1'b1;
          state_nxt = S_VIC;
        end
      end
      S_VIC: begin
        if (sts.hit_found) state_nxt = S_DONE;
        else begin
          cmd.step_vic = 1'b1;
          if (sts.scan_last) begin
            cmd.clr_scan = 1'b1;
            cmd.next_bucket = 1'b1;
            if (sts.vic_found || sts.bucket_last) state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          if (!sts.is_get) cmd.kind = K_IDX;
          else if (sts.hit_found) cmd.kind = K_HIT;
          else if (sts.vic_found) cmd.kind = K_VIC;
          else cmd.kind = K_FAIL;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

/* hdl/hbbc_dp.sv */
`timescale 1ns / 1ps
module hbbc_dp import hbbc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  hbbc_cmd_t       cmd,
  input  logic [1:0]      in_op,
  input  logic [7:0]      in_dev,
  input  logic [31:0]     in_blk,
  input  logic [4:0]      in_idx,
  input  logic            out_take,
  output hbbc_sts_t       sts,
  output logic            out_valid,
  output logic [8:0]      out_data
);
  logic [7:0]      dev_m   [BufferCount];
  logic [31:0]     blk_m   [BufferCount];
  logic [7:0]      refs_r  [BufferCount];
  logic            valid_r [BufferCount];
  logic [BktW-1:0] bkt_r   [BufferCount];
  logic [IdxW-1:0] rank_r  [BufferCount];

  logic [1:0]      op_r;
  logic [7:0]      dev_r;
  logic [31:0]     blk_r;
  logic [4:0]      idx_r;
  logic [BktW-1:0] own_r, q_r;
  logic [IdxW-1:0] scan_r;
  logic [IdxW-1:0] hit_r, vic_r;
  logic            hit_f_r, vic_f_r;
  logic [BktW-1:0] bcnt_r;
  logic            ov_r;
  logic [8:0]      od_r;

  // blk mod 13 via reciprocal multiply, quotient registered with the request
  logic [67:0] prod;
  logic [31:0] quo;
  logic [31:0] quo_r;
  logic [35:0] rem;
  assign prod = {36'd0, in_blk} * 68'h13B13B13C;
  assign quo  = prod[67:36];
  assign rem  = {4'd0, blk_r} - {quo_r, 2'b00} * 36'd1 * 36'd13 / 36'd4;

  logic [BktW-1:0] own_c;
  assign own_c = rem[BktW-1:0];

  logic [IdxW-1:0] sel, tgt;
  logic [IdxW-1:0] s;
  logic hmatch, vmatch;
  assign s = scan_r;
  assign hmatch = (bkt_r[s] == own_r) && (dev_m[s] == dev_r) && (blk_m[s] == blk_r);
  assign vmatch = (bkt_r[s] == q_r) && (refs_r[s] == 8'd0);

  assign sts.is_get      = (op_r == OP_GET);
  assign sts.scan_last   = (scan_r == IdxW'(BufferCount - 1));
  assign sts.hit_found   = hit_f_r;
  assign sts.vic_found   = vic_f_r || vmatch;
  assign sts.bucket_last = (bcnt_r == BktW'(BucketCount - 1));

  assign sel = idx_r;
  assign tgt = (cmd.kind == K_HIT) ? hit_r : (cmd.kind == K_VIC) ? vic_r : sel;

  logic [IdxW-1:0] tr;
  logic mk_new;
  assign tr = rank_r[tgt];
  always_comb begin
    mk_new = 1'b0;
    if (cmd.commit) begin
      if (cmd.kind == K_VIC) mk_new = 1'b1;
      if (cmd.kind == K_IDX && op_r == OP_RELEASE && refs_r[sel] == 8'd1) mk_new = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BufferCount; i++) begin
        dev_m[i] <= '0; blk_m[i] <= '0; refs_r[i] <= '0; valid_r[i] <= 1'b0;
        bkt_r[i] <= '0; rank_r[i] <= IdxW'(i);
      end
    end else begin
      if (cmd.load) begin
        op_r <= in_op; dev_r <= in_dev; blk_r <= in_blk; idx_r <= in_idx;
        quo_r <= quo;
      end
      if (cmd.clr_scan) scan_r <= '0;
      else if (cmd.step_hit || cmd.step_vic) scan_r <= scan_r + 1'b1;
      if (cmd.load) begin
        hit_f_r <= 1'b0; vic_f_r <= 1'b0; bcnt_r <= '0;
      end
      if (cmd.clr_scan && !cmd.step_hit && !cmd.step_vic) begin
        own_r <= own_c;
        q_r   <= (own_c == BktW'(BucketCount - 1)) ? '0 : own_c + 1'b1;
      end
      if (cmd.step_hit && hmatch && (!hit_f_r || rank_r[s] > rank_r[hit_r])) begin
        hit_f_r <= 1'b1; hit_r <= s;
      end
      if (cmd.step_vic && vmatch && (!vic_f_r || rank_r[s] < rank_r[vic_r])) begin
        vic_f_r <= 1'b1; vic_r <= s;
      end
      if (cmd.next_bucket && !sts.vic_found) begin
        bcnt_r <= bcnt_r + 1'b1;
        q_r <= (q_r == BktW'(BucketCount - 1)) ? '0 : q_r + 1'b1;
      end
      if (cmd.commit) begin
        case (cmd.kind)
          K_HIT: begin
            if (refs_r[tgt] == 8'hFF) od_r <= {ST_OVER, 1'b0, 1'b1, tgt};
            else begin
              refs_r[tgt] <= refs_r[tgt] + 1'b1;
              valid_r[tgt] <= 1'b1;
              od_r <= {ST_OK, ~valid_r[tgt], 1'b1, tgt};
            end
          end
          K_VIC: begin
            dev_m[tgt] <= dev_r; blk_m[tgt] <= blk_r; refs_r[tgt] <= 8'd1;
            valid_r[tgt] <= 1'b1; bkt_r[tgt] <= own_r;
            od_r <= {ST_OK, 1'b1, 1'b0, tgt};
          end
          K_FAIL: od_r <= {ST_NOFREE, 1'b0, 1'b0, IdxW'(0)};
          default: begin
            if (op_r == OP_PIN) begin
              if (refs_r[sel] == 8'hFF) od_r <= {ST_OVER, 2'b00, sel};
              else begin
                refs_r[sel] <= refs_r[sel] + 1'b1;
                od_r <= {ST_OK, 2'b00, sel};
              end
            end else if (refs_r[sel] == 8'd0) od_r <= {ST_UNDER, 2'b00, sel};
            else begin
              refs_r[sel] <= refs_r[sel] - 1'b1;
              od_r <= {ST_OK, 2'b00, sel};
            end
          end
        endcase
      end
      if (mk_new) begin
        for (int i = 0; i < BufferCount; i++)
          if (rank_r[i] > tr) rank_r[i] <= rank_r[i] - 1'b1;
        rank_r[tgt] <= IdxW'(BufferCount - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.commit) ov_r <= 1'b1;
    else if (out_take) ov_r <= 1'b0;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule

/* hdl/hashed_block_buffer_cache.sv */
`timescale 1ns / 1ps
// Hashed buffer cache of 32 entries in 13 buckets (block number mod 13).
// One request at a time: release, pin and unpin pass through the S_MOD
// and S_DONE states only; a get scans all entries once for a hit, then on
// a miss scans all entries once per bucket tried until a free entry is
// found or all 13 buckets have been tried. The scan counter walking the
// entry table sets how long a get lasts. The result is held in an output
// register until taken, and a held result delays the next one.
module hashed_block_buffer_cache import hbbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // opcode, device, block_number, buffer_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // entry_index, was_hit, needs_read, status
);
  hbbc_cmd_t cmd;
  hbbc_sts_t sts;
  logic [8:0] od;
  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  hbbc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_busy(m_axis_tvalid && !m_axis_tready), .sts(sts),
    .in_ready(s_axis_tready), .cmd(cmd)
  );

  hbbc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_op(s_axis_tdata[1:0]), .in_dev(s_axis_tdata[9:2]),
    .in_blk(s_axis_tdata[41:10]), .in_idx(s_axis_tdata[46:42]),
    .out_take(m_axis_tready), .sts(sts),
    .out_valid(m_axis_tvalid), .out_data(od)
  );

  assign m_axis_tdata = {7'd0, od};
endmodule

/* hdl/hbbc_checker.sv */
`timescale 1ns / 1ps
module hbbc_props (
  input logic        clk,
  input logic        rst_n,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while busy");
  a_nofree: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && m_axis_tdata[8:7] == 2'd1 |-> m_axis_tdata[6:0] == 7'd0)
    else $error("no free result carries data");
  a_hitread: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && m_axis_tdata[6] && m_axis_tdata[8:7] != 2'd0 |-> 1'b0)
    else $error("read flagged on error");
endmodule

bind hashed_block_buffer_cache hbbc_props u_chk (
  .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
